// ===== hw/rtl/chunked_upload_receiver_crc32_macros.svh =====
// Assertion helpers; clk and rst_n must be in scope where used.
`ifndef CHUNKED_UPLOAD_RECEIVER_CRC32_MACROS_SVH
`define CHUNKED_UPLOAD_RECEIVER_CRC32_MACROS_SVH

// expr must hold at every clock edge out of reset
`define CUR32_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante implies cons in the next cycle
`define CUR32_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cur32_pkg.sv =====
package cur32_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_HEADER = 3'd1,
        OP_BYTE   = 3'd2,
        OP_END    = 3'd3,
        OP_ABORT  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_READY = 3'd0,
        KIND_ACK   = 3'd1,
        KIND_ERROR = 3'd2,
        KIND_DONE  = 3'd3,
        KIND_ABORT = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_BUSY    = 3'd1,
        ERR_SESSION = 3'd2,
        ERR_SEQ     = 3'd3,
        ERR_SIZE    = 3'd4,
        ERR_CRC     = 3'd5
    } err_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  xfer_id;
        logic [31:0] seq;
        logic [15:0] frame_len;
        logic [7:0]  data_byte;
        logic [31:0] size;
        logic [31:0] crc_value;
        logic [31:0] req_seq;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  error_code;
        logic [7:0]  out_xfer_id;
        logic [31:0] ack_seq;
        logic [31:0] byte_count;
        logic [31:0] resp_seq;
    } rsp_t;

    // Result handed from the core to the output stage
    typedef struct packed {
        logic load;
        rsp_t rsp;
    } result_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/cur32_in_stage.sv =====
module cur32_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  cur32_pkg::req_t  req_data,
    input  logic             advance,
    output logic             item_valid,
    output cur32_pkg::req_t  item
);

    logic            valid_reg;
    logic            valid_next;
    cur32_pkg::req_t data_reg;

    assign req_stall  = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!req_stall)
        begin
            valid_next = req_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            data_reg <= req_data;
        end
    end

endmodule

// ===== hw/rtl/cur32_core.sv =====
`include "chunked_upload_receiver_crc32_macros.svh"

module cur32_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  cur32_pkg::req_t    item,
    output cur32_pkg::result_t result
);

    logic        session_open_reg, session_open_next;
    logic [7:0]  session_id_reg, session_id_next;
    logic [7:0]  next_id_reg, next_id_next;
    logic [31:0] session_req_seq_reg, session_req_seq_next;
    logic [31:0] expected_total_reg, expected_total_next;
    logic [31:0] bytes_accepted_reg, bytes_accepted_next;
    logic [31:0] next_seq_reg, next_seq_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic        frame_open_reg, frame_open_next;
    logic [15:0] frame_left_reg, frame_left_next;

    logic        do_close;
    logic [31:0] last_seq;
    logic [31:0] bumped_last_seq;
    logic [32:0] fill_sum;
    logic [7:0]  id_inc;

    assign last_seq = (next_seq_reg == 32'd0) ? 32'd0 : (next_seq_reg - 32'd1);
    // last accepted seq once this frame completes; a wrapped counter reads as none
    assign bumped_last_seq = (next_seq_reg == 32'hFFFF_FFFF) ? 32'd0 : next_seq_reg;
    assign fill_sum = {1'b0, bytes_accepted_reg} + {17'd0, item.frame_len};
    assign id_inc   = next_id_reg + 8'd1;

    always_comb
    begin
        session_open_next    = session_open_reg;
        session_id_next      = session_id_reg;
        next_id_next         = next_id_reg;
        session_req_seq_next = session_req_seq_reg;
        expected_total_next  = expected_total_reg;
        bytes_accepted_next  = bytes_accepted_reg;
        next_seq_next        = next_seq_reg;
        running_crc_next     = running_crc_reg;
        frame_open_next      = frame_open_reg;
        frame_left_next      = frame_left_reg;
        do_close             = 1'b0;
        result               = '0;

        if (go)
        begin
            case (item.op)
                cur32_pkg::OP_START:
                begin
                    result.load         = 1'b1;
                    result.rsp.resp_seq = item.req_seq;
                    if (session_open_reg)
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_BUSY;
                    end
                    else
                    begin
                        // closed session already holds reset values elsewhere
                        session_open_next       = 1'b1;
                        session_id_next         = next_id_reg;
                        next_id_next            = (id_inc == 8'd0) ? 8'd1 : id_inc;
                        session_req_seq_next    = item.req_seq;
                        expected_total_next     = item.size;
                        result.rsp.kind         = cur32_pkg::KIND_READY;
                        result.rsp.out_xfer_id  = next_id_reg;
                        result.rsp.byte_count   = item.size;
                    end
                end
                cur32_pkg::OP_HEADER:
                begin
                    result.load = 1'b1;
                    if (!session_open_reg || item.xfer_id != session_id_reg)
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_SESSION;
                        result.rsp.resp_seq   = session_req_seq_reg;
                    end
                    else if (frame_open_reg)
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_SEQ;
                        result.rsp.resp_seq   = session_req_seq_reg;
                        do_close              = 1'b1;
                    end
                    else if (item.seq < next_seq_reg)
                    begin
                        // duplicate: resend last ack
                        result.rsp.kind        = cur32_pkg::KIND_ACK;
                        result.rsp.out_xfer_id = session_id_reg;
                        result.rsp.ack_seq     = last_seq;
                        result.rsp.byte_count  = bytes_accepted_reg;
                    end
                    else if (item.seq != next_seq_reg)
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_SEQ;
                        result.rsp.resp_seq   = session_req_seq_reg;
                        do_close              = 1'b1;
                    end
                    else if (fill_sum > {1'b0, expected_total_reg})
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_SIZE;
                        result.rsp.resp_seq   = session_req_seq_reg;
                        do_close              = 1'b1;
                    end
                    else if (item.frame_len == 16'd0)
                    begin
                        next_seq_next          = next_seq_reg + 32'd1;
                        result.rsp.kind        = cur32_pkg::KIND_ACK;
                        result.rsp.out_xfer_id = session_id_reg;
                        result.rsp.ack_seq     = bumped_last_seq;
                        result.rsp.byte_count  = bytes_accepted_reg;
                    end
                    else
                    begin
                        result.load     = 1'b0;
                        frame_open_next = 1'b1;
                        frame_left_next = item.frame_len;
                    end
                end
                cur32_pkg::OP_BYTE:
                begin
                    if (frame_open_reg)
                    begin
                        running_crc_next    = cur32_pkg::crc_byte(running_crc_reg,
                                                                  item.data_byte);
                        bytes_accepted_next = bytes_accepted_reg + 32'd1;
                        frame_left_next     = frame_left_reg - 16'd1;
                        if (frame_left_reg == 16'd1)
                        begin
                            frame_open_next        = 1'b0;
                            next_seq_next          = next_seq_reg + 32'd1;
                            result.load            = 1'b1;
                            result.rsp.kind        = cur32_pkg::KIND_ACK;
                            result.rsp.out_xfer_id = session_id_reg;
                            result.rsp.ack_seq     = bumped_last_seq;
                            result.rsp.byte_count  = bytes_accepted_next;
                        end
                    end
                end
                cur32_pkg::OP_END:
                begin
                    result.load         = 1'b1;
                    result.rsp.resp_seq = item.req_seq;
                    if (!session_open_reg)
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_SESSION;
                    end
                    else if (frame_open_reg || bytes_accepted_reg != expected_total_reg)
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_SIZE;
                        do_close              = 1'b1;
                    end
                    else if (~running_crc_reg != item.crc_value)
                    begin
                        result.rsp.kind       = cur32_pkg::KIND_ERROR;
                        result.rsp.error_code = cur32_pkg::ERR_CRC;
                        do_close              = 1'b1;
                    end
                    else
                    begin
                        result.rsp.kind        = cur32_pkg::KIND_DONE;
                        result.rsp.out_xfer_id = session_id_reg;
                        result.rsp.ack_seq     = last_seq;
                        result.rsp.byte_count  = bytes_accepted_reg;
                        do_close               = 1'b1;
                    end
                end
                cur32_pkg::OP_ABORT:
                begin
                    result.load         = 1'b1;
                    result.rsp.kind     = cur32_pkg::KIND_ABORT;
                    result.rsp.resp_seq = item.req_seq;
                    do_close            = 1'b1;
                end
                default:
                begin
                    result.load = 1'b0;
                end
            endcase
        end

        if (do_close)
        begin
            session_open_next    = 1'b0;
            session_id_next      = 8'd0;
            session_req_seq_next = 32'd0;
            expected_total_next  = 32'd0;
            bytes_accepted_next  = 32'd0;
            next_seq_next        = 32'd0;
            running_crc_next     = cur32_pkg::CRC_INIT;
            frame_open_next      = 1'b0;
            frame_left_next      = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_open_reg    <= 1'b0;
            session_id_reg      <= 8'd0;
            next_id_reg         <= 8'd1;
            session_req_seq_reg <= 32'd0;
            expected_total_reg  <= 32'd0;
            bytes_accepted_reg  <= 32'd0;
            next_seq_reg        <= 32'd0;
            running_crc_reg     <= cur32_pkg::CRC_INIT;
            frame_open_reg      <= 1'b0;
            frame_left_reg      <= 16'd0;
        end
        else
        begin
            session_open_reg    <= session_open_next;
            session_id_reg      <= session_id_next;
            next_id_reg         <= next_id_next;
            session_req_seq_reg <= session_req_seq_next;
            expected_total_reg  <= expected_total_next;
            bytes_accepted_reg  <= bytes_accepted_next;
            next_seq_reg        <= next_seq_next;
            running_crc_reg     <= running_crc_next;
            frame_open_reg      <= frame_open_next;
            frame_left_reg      <= frame_left_next;
        end
    end

    `CUR32_ASSERT_ALWAYS(a_frame_in_session, !frame_open_reg || session_open_reg, "frame open without session")
    `CUR32_ASSERT_ALWAYS(a_frame_left_nz, !frame_open_reg || frame_left_reg != 16'd0, "open frame with no bytes left")
    `CUR32_ASSERT_ALWAYS(a_id_nz, next_id_reg != 8'd0 && (!session_open_reg || session_id_reg != 8'd0), "zero transfer id")
    `CUR32_ASSERT_NEXT(a_idle_holds, !go, $stable(bytes_accepted_reg) && $stable(running_crc_reg), "state moved without an item")

endmodule

// ===== hw/rtl/cur32_out_stage.sv =====
module cur32_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  cur32_pkg::result_t result,
    output logic               free,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cur32_pkg::rsp_t    rsp_data
);

    logic            valid_reg;
    logic            valid_next;
    cur32_pkg::rsp_t data_reg;

    assign free      = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = result.load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && result.load)
        begin
            data_reg <= result.rsp;
        end
    end

endmodule

// ===== hw/rtl/chunked_upload_receiver_crc32.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------
// request   | in        | req_valid/req_stall  | req_data  (cur32_pkg::req_t)
// response  | out       | rsp_valid/rsp_stall  | rsp_data  (cur32_pkg::rsp_t)
//
// One request per cycle sustained while responses are not stalled; a request that
// produces a response passes the input register, then the result register,
// before rsp_valid rises.
// The per-cycle path is the core's one-byte CRC-32 update and 33-bit size check.
// rst_n is asynchronous; reset closes the session and sets the next id to 1.
// rsp_stall backs up into req_stall in the same cycle while the input register
// and the result register are both full; stalled requests and responses keep their values.
module chunked_upload_receiver_crc32 (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cur32_pkg::req_t req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cur32_pkg::rsp_t rsp_data
);

    logic               item_valid;
    cur32_pkg::req_t    item;
    logic               free;
    logic               go;
    cur32_pkg::result_t result;

    // A request in the input register is processed once the result
    // register can take whatever it produces.
    assign go = item_valid && free;

    cur32_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .advance    (free),
        .item_valid (item_valid),
        .item       (item)
    );

    // Session state, header checks, CRC update and response build
    cur32_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (item),
        .result (result)
    );

    cur32_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .free      (free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== tb/upload_check_pkg.sv =====
`timescale 1ns / 100ps

package upload_check_pkg;
    import cur32_pkg::*;

    // Predicts the upload receiver and keeps the responses still owed by the block.
    class upload_scoreboard;
        bit          in_session;
        logic [7:0]  sid;
        logic [7:0]  nid;
        logic [31:0] start_tag;
        logic [31:0] total;
        logic [31:0] accepted;
        logic [31:0] nseq;
        logic [31:0] crc;
        bit          in_frame;
        logic [15:0] fleft;
        rsp_t        pending[$];
        int unsigned fails;
        int unsigned seen;

        function new();
            close_session();
            nid = 8'd1;
            fails = 0;
            seen = 0;
        endfunction

        // All session state but the id counter goes back to its idle value
        function void close_session();
            in_session = 1'b0;
            sid = 8'd0;
            start_tag = 32'd0;
            total = 32'd0;
            accepted = 32'd0;
            nseq = 32'd0;
            crc = CRC_INIT;
            in_frame = 1'b0;
            fleft = 16'd0;
        endfunction

        // Reflected CRC-32, one data bit per pass, LSB first
        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++)
            begin
                fb = c[0] ^ b[i];
                c = c >> 1;
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function logic [31:0] last_seq();
            return (nseq == 32'd0) ? 32'd0 : nseq - 32'd1;
        endfunction

        function rsp_t ack_now();
            rsp_t e;
            e = '0;
            e.kind = KIND_ACK;
            e.error_code = ERR_NONE;
            e.out_xfer_id = sid;
            e.ack_seq = last_seq();
            e.byte_count = accepted;
            return e;
        endfunction

        function rsp_t fault(err_t code, logic [31:0] tag);
            rsp_t e;
            e = '0;
            e.kind = KIND_ERROR;
            e.error_code = code;
            e.resp_seq = tag;
            return e;
        endfunction

        // Advances the state by one request; returns 1 when a response is due
        function bit predict(input req_t r, output rsp_t e);
            e = '0;
            case (r.op)
                OP_START:
                begin
                    if (in_session)
                    begin
                        e = fault(ERR_BUSY, r.req_seq);
                        return 1'b1;
                    end
                    close_session();
                    in_session = 1'b1;
                    sid = nid;
                    nid = nid + 8'd1;
                    if (nid == 8'd0)
                        nid = 8'd1;
                    start_tag = r.req_seq;
                    total = r.size;
                    e.kind = KIND_READY;
                    e.error_code = ERR_NONE;
                    e.out_xfer_id = sid;
                    e.byte_count = r.size;
                    e.resp_seq = r.req_seq;
                    return 1'b1;
                end
                OP_HEADER:
                begin
                    if (!in_session || r.xfer_id != sid)
                    begin
                        e = fault(ERR_SESSION, start_tag);
                        return 1'b1;
                    end
                    if (in_frame)
                    begin
                        e = fault(ERR_SEQ, start_tag);
                        close_session();
                        return 1'b1;
                    end
                    if (r.seq < nseq)
                    begin
                        e = ack_now();
                        return 1'b1;
                    end
                    if (r.seq != nseq)
                    begin
                        e = fault(ERR_SEQ, start_tag);
                        close_session();
                        return 1'b1;
                    end
                    if (({1'b0, accepted} + {17'd0, r.frame_len}) > {1'b0, total})
                    begin
                        e = fault(ERR_SIZE, start_tag);
                        close_session();
                        return 1'b1;
                    end
                    if (r.frame_len == 16'd0)
                    begin
                        nseq = nseq + 32'd1;
                        e = ack_now();
                        return 1'b1;
                    end
                    in_frame = 1'b1;
                    fleft = r.frame_len;
                    return 1'b0;
                end
                OP_BYTE:
                begin
                    if (!in_frame)
                        return 1'b0;
                    crc = crc_step(crc, r.data_byte);
                    accepted = accepted + 32'd1;
                    fleft = fleft - 16'd1;
                    if (fleft != 16'd0)
                        return 1'b0;
                    in_frame = 1'b0;
                    nseq = nseq + 32'd1;
                    e = ack_now();
                    return 1'b1;
                end
                OP_END:
                begin
                    if (!in_session)
                    begin
                        e = fault(ERR_SESSION, r.req_seq);
                        return 1'b1;
                    end
                    if (in_frame || accepted != total)
                        e = fault(ERR_SIZE, r.req_seq);
                    else if (~crc != r.crc_value)
                        e = fault(ERR_CRC, r.req_seq);
                    else
                    begin
                        e.kind = KIND_DONE;
                        e.error_code = ERR_NONE;
                        e.out_xfer_id = sid;
                        e.ack_seq = last_seq();
                        e.byte_count = accepted;
                        e.resp_seq = r.req_seq;
                    end
                    close_session();
                    return 1'b1;
                end
                OP_ABORT:
                begin
                    close_session();
                    e.kind = KIND_ABORT;
                    e.error_code = ERR_NONE;
                    e.resp_seq = r.req_seq;
                    return 1'b1;
                end
                default:
                    return 1'b0;
            endcase
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            if (predict(r, e))
                pending.push_back(e);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH response %0d: %s", $time, seen, msg);
            fails++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            seen++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected response %h", got));
                return;
            end
            want = pending.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
            compare_field("out_xfer_id", 32'(got.out_xfer_id), 32'(want.out_xfer_id));
            compare_field("ack_seq", got.ack_seq, want.ack_seq);
            compare_field("byte_count", got.byte_count, want.byte_count);
            compare_field("resp_seq", got.resp_seq, want.resp_seq);
        endtask
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cur32_pkg::*;
    import upload_check_pkg::*;

    localparam int HALF_PERIOD = 5;
    // Watchdog limit for the slowest legal run, with sender gaps, heavy response
    // stall and the drains.
    localparam int unsigned CYCLE_LIMIT = 300000;
    // Two-stage pipe; ignored requests can still be in flight after the last response
    localparam int QUIET_CYCLES = 8;
    // Op codes the block decodes as nothing
    localparam logic [2:0] OP_RESERVED     = 3'd5;
    localparam logic [2:0] OP_RESERVED_TOP = 3'd7;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    upload_scoreboard sb = new();   // checks what the block returns
    upload_scoreboard plan = new(); // generator's view of the block, updated at issue time

    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned counted = 0;       // requests that do real work (ignored ones excluded)
    int unsigned stall_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    chunked_upload_receiver_crc32 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Response side backpressure: modes change at random intervals so
    // stalls land on every phase of a session, with clean stretches too.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    // Both handshakes sampled at the edge, before any of this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_data);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp_data);
        end
    end

    // Request with every field random except the op
    function automatic req_t blank(logic [2:0] op);
        req_t r;
        r.op = op;
        r.xfer_id = 8'($urandom);
        r.seq = $urandom;
        r.frame_len = 16'($urandom);
        r.data_byte = 8'($urandom);
        r.size = $urandom;
        r.crc_value = $urandom;
        r.req_seq = $urandom;
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    // valid stays high across back-to-back requests of one burst.
    task automatic issue(input req_t r);
        rsp_t unused;
        bit was_framing;
        bit has_rsp;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        was_framing = plan.in_frame;
        has_rsp = plan.predict(r, unused);
        if (has_rsp || was_framing || plan.in_frame)
            counted++;
        req_data <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Hold off until every owed response is back, then let the pipe empty
    task automatic wait_for_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // Mostly well-formed uploads with random content; the rest is noise and
    // broken sequences (dup, gap, wrong id, overrun, bad crc, busy, abort).
    function automatic req_t pick_item();
        req_t r;
        int unsigned dice;
        logic [31:0] room;
        logic [31:0] len;
        r = blank(3'($urandom_range(0, 7)));
        if ($urandom_range(0, 99) < 8)
            return r;
        dice = $urandom_range(0, 99);
        if (!plan.in_session)
        begin
            r.op = OP_START;
            if (dice < 70)
                r.size = $urandom_range(0, 40);
            else if (dice < 85)
                r.size = 32'd0;
            return r;
        end
        if (plan.in_frame)
        begin
            // a huge announced frame would eat the whole run: bail out of it
            r.op = (plan.fleft > 16'd24 || dice < 3) ? OP_ABORT : OP_BYTE;
            return r;
        end
        room = plan.total - plan.accepted;
        r.xfer_id = plan.sid;
        r.seq = plan.nseq;
        if ((room == 32'd0 && dice < 70) || dice < 8)
        begin
            r.op = OP_END;
            r.crc_value = ~plan.crc;
            if ($urandom_range(0, 9) == 0)
                r.crc_value[$urandom_range(0, 31)] ^= 1'b1;
        end
        else if (dice < 12)
            r.op = OP_START;
        else if (dice < 16)
            r.op = OP_ABORT;
        else if (dice < 20 && plan.nseq != 32'd0)
        begin
            r.op = OP_HEADER;
            r.seq = $urandom_range(0, plan.nseq - 32'd1);
        end
        else if (dice < 23)
        begin
            r.op = OP_HEADER;
            r.seq = plan.nseq + $urandom_range(1, 1000);
        end
        else if (dice < 26)
        begin
            r.op = OP_HEADER;
            r.xfer_id[$urandom_range(0, 7)] ^= 1'b1;
        end
        else
        begin
            r.op = OP_HEADER;
            if (dice < 29 && room < 32'd65535)
                len = room + 32'd1;
            else
            begin
                len = (dice < 40) ? 32'd0 : $urandom_range(1, 6);
                if (len > room)
                    len = room;
            end
            r.frame_len = len[15:0];
        end
        return r;
    endfunction

    initial
    begin
        req_t r;
        int unsigned pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: no session yet ----
        r = blank(OP_HEADER); r.xfer_id = 8'd1; r.seq = 32'd0;
        issue(r);                                           // invalid session, tag 0
        r = blank(OP_END);
        issue(r);                                           // end without session
        r = blank(OP_BYTE);
        issue(r);                                           // stray byte, ignored
        r = blank(OP_RESERVED);
        issue(r);                                           // unused op, ignored
        r = blank(OP_RESERVED_TOP);
        issue(r);                                           // unused op, ignored
        r = blank(OP_ABORT);
        issue(r);                                           // abort with nothing open

        // max announced size, max tag
        r = blank(OP_START); r.size = 32'hFFFF_FFFF; r.req_seq = 32'hFFFF_FFFF;
        issue(r);
        r = blank(OP_START);
        issue(r);                                           // busy
        r = blank(OP_HEADER); r.xfer_id = ~plan.sid; r.seq = 32'd0;
        issue(r);                                           // wrong id
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'd0; r.frame_len = 16'd0;
        issue(r);                                           // empty frame, acked at once
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'd0; r.frame_len = 16'd5;
        issue(r);                                           // duplicate, ack resent
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'd1;
        r.frame_len = 16'hFFFF;
        issue(r);                                           // largest frame opens
        r = blank(OP_BYTE); r.data_byte = 8'hFF;
        issue(r);
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'd2;
        issue(r);                                           // header inside a frame

        // sequence gap at the top of the range
        r = blank(OP_START); r.size = 32'd2;
        issue(r);
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'hFFFF_FFFF;
        issue(r);

        // overrun
        r = blank(OP_START); r.size = 32'd2;
        issue(r);
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'd0; r.frame_len = 16'd3;
        issue(r);

        // end while a frame is still open
        r = blank(OP_START); r.size = 32'd2;
        issue(r);
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'd0; r.frame_len = 16'd2;
        issue(r);
        r = blank(OP_BYTE); r.data_byte = 8'h00;
        issue(r);
        r = blank(OP_END);
        issue(r);

        // crc fail on a complete upload
        r = blank(OP_START); r.size = 32'd1;
        issue(r);
        r = blank(OP_HEADER); r.xfer_id = plan.sid; r.seq = 32'd0; r.frame_len = 16'd1;
        issue(r);
        r = blank(OP_BYTE);
        issue(r);
        r = blank(OP_END); r.crc_value = ~plan.crc ^ 32'h1;
        issue(r);

        wait_for_quiet();

        // ---- id churn: enough sessions to wrap the 8-bit id past zero ----
        repeat (260)
        begin
            r = blank(OP_START); r.size = 32'd0;
            issue(r);
            pick = $urandom_range(0, 3);
            r = blank((pick == 0) ? OP_ABORT : OP_END);
            r.crc_value = ~plan.crc;
            if (pick == 1)
                r.crc_value[$urandom_range(0, 31)] ^= 1'b1;
            issue(r);
        end

        wait_for_quiet();

        // ---- random uploads ----
        while (counted < 1000)
            issue(pick_item());
        wait_for_quiet();
        while (counted < 1450)
            issue(pick_item());

        wait_for_quiet();
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.pending.size()));

        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cur32_pkg.sv
hw/rtl/cur32_in_stage.sv
hw/rtl/cur32_core.sv
hw/rtl/cur32_out_stage.sv
hw/rtl/chunked_upload_receiver_crc32.sv
tb/upload_check_pkg.sv
tb/tb_top.sv
